// ===== rtl/fba_pkg.sv =====
// Package for the file block allocator: item types, action/status codes,
// sequencer states and default sizing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

  localparam int NUM_BLOCKS_DEF      = 4096;
  localparam int FILE_SLOTS_DEF      = 128;
  localparam int BLOCKS_PER_FILE_DEF = 1250;
  localparam int BLOCK_BYTES_DEF     = 8192;
  localparam int DATA_BASE_DEF       = 130;
  localparam logic [23:0] MAX_FILE_BYTES_RST = 24'd10240000;

  // bitmap row width (blocks per memory word)
  localparam int ROW_BITS = 16;
  localparam int ROW_LOG  = 4;

  typedef enum logic [2:0] {
    ACT_ALLOC  = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_QUERY  = 3'd2,
    ACT_READ   = 3'd3,
    ACT_FORMAT = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NO_SPACE = 3'd1,
    STAT_TOO_BIG  = 3'd2,
    STAT_NO_SLOT  = 3'd3,
    STAT_BAD_SLOT = 3'd4,
    STAT_PAST_END = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    FSM_CLR,
    FSM_IDLE,
    FSM_A_CHK,
    FSM_A_SLOT,
    FSM_A_BASE,
    FSM_A_RD,
    FSM_A_LD,
    FSM_A_CL,
    FSM_D_CHK,
    FSM_D_TOT,
    FSM_D_LST,
    FSM_D_MAP,
    FSM_D_UPD,
    FSM_R_CHK,
    FSM_R_TOT,
    FSM_R_DAT,
    FSM_FIN,
    FSM_DONE
  } fsm_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] file_bytes;
    logic [6:0]  file_index;
    logic [10:0] block_position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  slot_out;
    logic [12:0] block_number;
    logic [10:0] block_count;
    logic [25:0] free_bytes;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/file_block_allocator_core.sv =====
// File block allocator top level: sequencer, bitmap, slot table, block lists.
// Depends on fba_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// - Input channel (in_valid/in_stall/in_item) takes one command item:
//   allocate, delete, free-space query, block-list read or format.
// - Result channel (out_valid/out_stall/out_item) returns one item per command.
// - cfg_we/cfg_wdata write max_file_bytes; write only while idle.
// - One command at a time; in_stall is high until the sequencer is idle.
// - Allocate time grows with the slots scanned, the blocks needed and the
//   bitmap rows touched; delete time grows with the blocks held. Both
//   are set by the bitmap memory (16 blocks per word) and the block-list
//   memory.
// - Format and reset run a clearing pass over the bitmap, one word per
//   cycle, with the input stalled meanwhile.
// - A finished result sits in the output register; if out_stall holds it,
//   the sequencer waits with the next result until the register frees up.
// - NUM_BLOCKS must be a multiple of 16.
module file_block_allocator_core
  import fba_pkg::*;
#(
  parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
  parameter int FILE_SLOTS      = FILE_SLOTS_DEF,
  parameter int BLOCKS_PER_FILE = BLOCKS_PER_FILE_DEF,
  parameter int BLOCK_BYTES     = BLOCK_BYTES_DEF,
  parameter int DATA_BASE       = DATA_BASE_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic [23:0] cfg_wdata
);

  localparam int ROWS   = NUM_BLOCKS / ROW_BITS;
  localparam int ROWW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDXW   = $clog2(NUM_BLOCKS);
  localparam int LISTD  = FILE_SLOTS * BLOCKS_PER_FILE;
  localparam int LAW    = (LISTD > 1) ? $clog2(LISTD) : 1;
  localparam int SLW    = $clog2(FILE_SLOTS);
  localparam int KW     = $clog2(BLOCKS_PER_FILE + 1);
  localparam int FTW    = $clog2(NUM_BLOCKS + 1);
  localparam int BBW    = $clog2(BLOCK_BYTES + 1);
  localparam int FBW    = FTW + BBW;
  localparam int CMPW   = (FBW > 34) ? FBW : 34;
  localparam longint LIMIT_BYTES = longint'(BLOCKS_PER_FILE) * longint'(BLOCK_BYTES);

  // memories
  logic [ROW_BITS-1:0] bm_mem [ROWS];
  logic [IDXW-1:0]     ls_mem [LISTD];
  logic [KW-1:0]       tt_mem [FILE_SLOTS];

  logic                bm_we, ls_we, tt_we;
  logic [ROWW-1:0]     bm_waddr, bm_raddr;
  logic [ROW_BITS-1:0] bm_wdata, bm_q;
  logic [LAW-1:0]      ls_waddr, ls_raddr;
  logic [IDXW-1:0]     ls_wdata, ls_q;
  logic [SLW-1:0]      tt_waddr, tt_raddr;
  logic [KW-1:0]       tt_wdata, tt_q;

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    bm_q <= bm_mem[bm_raddr];
    if (ls_we) ls_mem[ls_waddr] <= ls_wdata;
    ls_q <= ls_mem[ls_raddr];
    if (tt_we) tt_mem[tt_waddr] <= tt_wdata;
    tt_q <= tt_mem[tt_raddr];
  end

  // registers
  fsm_t                state_r, state_nxt;
  in_item_t            item_r, item_nxt;
  logic [SLW-1:0]      sidx_r, sidx_nxt;
  logic [LAW-1:0]      base_r, base_nxt;
  logic [KW-1:0]       k_r, k_nxt, tot_r, tot_nxt;
  logic [CMPW-1:0]     acc_r, acc_nxt;
  logic [ROWW-1:0]     row_r, row_nxt;
  logic [ROW_BITS-1:0] rowd_r, rowd_nxt;
  logic [IDXW-1:0]     first_r, first_nxt, blk_r, blk_nxt;
  logic [FTW-1:0]      free_r, free_nxt;
  logic [FILE_SLOTS-1:0] svalid_r, svalid_nxt;
  logic [23:0]         max_r;
  status_t             status_r, status_nxt;
  logic [6:0]          rslot_r, rslot_nxt;
  logic [12:0]         rblk_r, rblk_nxt;
  logic [10:0]         rcnt_r, rcnt_nxt;
  logic                fmt_r, fmt_nxt;
  out_item_t           out_r, out_nxt;
  logic                outv_r, outv_nxt;
  logic [FBW-1:0]      fb_r;

  // lowest zero in the held bitmap word
  logic                zfound;
  logic [ROW_LOG-1:0]  zpos;
  always_comb begin
    zfound = 1'b0;
    zpos   = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!rowd_r[i]) begin
        zfound = 1'b1;
        zpos   = ROW_LOG'(i);
      end
    end
  end

  logic            slot_bad;
  logic [SLW-1:0]  idx_s;
  logic [IDXW-1:0] new_blk;
  logic [ROW_BITS-1:0] new_row, one_hot;
  logic [CMPW-1:0] bytes_x, acc_step;

  assign idx_s    = SLW'(item_r.file_index);
  assign slot_bad = (32'(item_r.file_index) >= FILE_SLOTS) || !svalid_r[idx_s];
  assign new_blk  = IDXW'({row_r, zpos});
  assign one_hot  = ROW_BITS'(1) << zpos;
  assign new_row  = rowd_r | one_hot;
  assign bytes_x  = CMPW'(item_r.file_bytes);
  assign acc_step = acc_r + CMPW'(BLOCK_BYTES);

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    sidx_nxt   = sidx_r;
    base_nxt   = base_r;
    k_nxt      = k_r;
    tot_nxt    = tot_r;
    acc_nxt    = acc_r;
    row_nxt    = row_r;
    rowd_nxt   = rowd_r;
    first_nxt  = first_r;
    blk_nxt    = blk_r;
    free_nxt   = free_r;
    svalid_nxt = svalid_r;
    status_nxt = status_r;
    rslot_nxt  = rslot_r;
    rblk_nxt   = rblk_r;
    rcnt_nxt   = rcnt_r;
    fmt_nxt    = fmt_r;
    out_nxt    = out_r;
    outv_nxt   = outv_r;
    bm_we = 1'b0; bm_waddr = row_r; bm_wdata = rowd_r; bm_raddr = row_r;
    ls_we = 1'b0; ls_waddr = base_r + LAW'(k_r); ls_wdata = new_blk;
    ls_raddr = base_r + LAW'(k_r);
    tt_we = 1'b0; tt_waddr = sidx_r; tt_wdata = k_r; tt_raddr = idx_s;

    if (outv_r && !out_stall) outv_nxt = 1'b0;

    case (state_r)
      FSM_CLR: begin
        bm_we    = 1'b1;
        bm_wdata = '0;
        row_nxt  = row_r + ROWW'(1);
        if (32'(row_r) == ROWS - 1) begin
          row_nxt   = '0;
          state_nxt = fmt_r ? FSM_FIN : FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_item;
          status_nxt = STAT_OK;
          rslot_nxt  = '0;
          rblk_nxt   = '0;
          rcnt_nxt   = '0;
          case (in_item.action)
            ACT_ALLOC:  state_nxt = FSM_A_CHK;
            ACT_DELETE: state_nxt = FSM_D_CHK;
            ACT_READ:   state_nxt = FSM_R_CHK;
            ACT_FORMAT: begin
              svalid_nxt = '0;
              free_nxt   = FTW'(NUM_BLOCKS);
              fmt_nxt    = 1'b1;
              row_nxt    = '0;
              state_nxt  = FSM_CLR;
            end
            default:    state_nxt = FSM_FIN;
          endcase
        end
      end
      // allocate: checks in order, then slot scan
      FSM_A_CHK: begin
        sidx_nxt = '0;
        if (bytes_x > CMPW'(fb_r)) begin
          status_nxt = STAT_NO_SPACE;
          state_nxt  = FSM_FIN;
        end else if (item_r.file_bytes > 32'(max_r) ||
                     longint'(item_r.file_bytes) > LIMIT_BYTES) begin
          status_nxt = STAT_TOO_BIG;
          state_nxt  = FSM_FIN;
        end else begin
          state_nxt = FSM_A_SLOT;
        end
      end
      FSM_A_SLOT: begin
        if (!svalid_r[sidx_r]) begin
          state_nxt = FSM_A_BASE;
        end else if (32'(sidx_r) == FILE_SLOTS - 1) begin
          status_nxt = STAT_NO_SLOT;
          state_nxt  = FSM_FIN;
        end else begin
          sidx_nxt = sidx_r + SLW'(1);
        end
      end
      FSM_A_BASE: begin
        base_nxt  = LAW'(32'(sidx_r) * BLOCKS_PER_FILE);
        k_nxt     = '0;
        acc_nxt   = '0;
        row_nxt   = '0;
        state_nxt = FSM_A_RD;
      end
      FSM_A_RD: begin
        if (acc_r >= bytes_x) begin
          svalid_nxt[sidx_r] = 1'b1;
          tt_we      = 1'b1;
          rslot_nxt  = 7'(sidx_r);
          rblk_nxt   = (k_r != '0) ? 13'(32'(first_r) + DATA_BASE) : 13'd0;
          rcnt_nxt   = 11'(k_r);
          row_nxt    = '0;
          state_nxt  = FSM_FIN;
        end else begin
          state_nxt = FSM_A_LD;
        end
      end
      FSM_A_LD: begin
        rowd_nxt  = bm_q;
        state_nxt = FSM_A_CL;
      end
      FSM_A_CL: begin
        if (!zfound) begin
          bm_we     = 1'b1;
          row_nxt   = row_r + ROWW'(1);
          state_nxt = FSM_A_RD;
        end else begin
          rowd_nxt = new_row;
          ls_we    = 1'b1;
          if (k_r == '0) first_nxt = new_blk;
          k_nxt    = k_r + KW'(1);
          acc_nxt  = acc_step;
          free_nxt = free_r - FTW'(1);
          if (acc_step >= bytes_x) begin
            bm_we     = 1'b1;
            bm_wdata  = new_row;
            state_nxt = FSM_A_RD;
          end
        end
      end
      // delete: walk the list, clear used bits
      FSM_D_CHK: begin
        rslot_nxt = item_r.file_index;
        base_nxt  = LAW'(32'(idx_s) * BLOCKS_PER_FILE);
        if (slot_bad) begin
          status_nxt = STAT_BAD_SLOT;
          state_nxt  = FSM_FIN;
        end else begin
          state_nxt = FSM_D_TOT;
        end
      end
      FSM_D_TOT: begin
        tot_nxt   = tt_q;
        k_nxt     = '0;
        state_nxt = FSM_D_LST;
      end
      FSM_D_LST: begin
        if (k_r >= tot_r) begin
          svalid_nxt[idx_s] = 1'b0;
          state_nxt = FSM_FIN;
        end else begin
          state_nxt = FSM_D_MAP;
        end
      end
      FSM_D_MAP: begin
        blk_nxt   = ls_q;
        bm_raddr  = ROWW'(ls_q >> ROW_LOG);
        state_nxt = FSM_D_UPD;
      end
      FSM_D_UPD: begin
        if (bm_q[blk_r[ROW_LOG-1:0]]) begin
          bm_we    = 1'b1;
          bm_waddr = ROWW'(blk_r >> ROW_LOG);
          bm_wdata = bm_q & ~(ROW_BITS'(1) << blk_r[ROW_LOG-1:0]);
          free_nxt = free_r + FTW'(1);
        end
        k_nxt     = k_r + KW'(1);
        state_nxt = FSM_D_LST;
      end
      // block-list read
      FSM_R_CHK: begin
        rslot_nxt = item_r.file_index;
        base_nxt  = LAW'(32'(idx_s) * BLOCKS_PER_FILE);
        if (slot_bad) begin
          status_nxt = STAT_BAD_SLOT;
          state_nxt  = FSM_FIN;
        end else begin
          state_nxt = FSM_R_TOT;
        end
      end
      FSM_R_TOT: begin
        rcnt_nxt = 11'(tt_q);
        ls_raddr = base_r + LAW'(item_r.block_position);
        if (32'(item_r.block_position) >= 32'(tt_q)) begin
          status_nxt = STAT_PAST_END;
          state_nxt  = FSM_FIN;
        end else begin
          state_nxt = FSM_R_DAT;
        end
      end
      FSM_R_DAT: begin
        rblk_nxt  = 13'(32'(ls_q) + DATA_BASE);
        state_nxt = FSM_FIN;
      end
      // lets the free-bytes product settle
      FSM_FIN: begin
        fmt_nxt   = 1'b0;
        state_nxt = FSM_DONE;
      end
      FSM_DONE: begin
        if (!outv_r || !out_stall) begin
          out_nxt.status       = status_r;
          out_nxt.slot_out     = rslot_r;
          out_nxt.block_number = rblk_r;
          out_nxt.block_count  = rcnt_r;
          out_nxt.free_bytes   = 26'(fb_r);
          outv_nxt  = 1'b1;
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FSM_CLR;
      row_r    <= '0;
      fmt_r    <= 1'b0;
      free_r   <= FTW'(NUM_BLOCKS);
      svalid_r <= '0;
      max_r    <= MAX_FILE_BYTES_RST;
      outv_r   <= 1'b0;
      k_r      <= '0;
      sidx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      fmt_r    <= fmt_nxt;
      free_r   <= free_nxt;
      svalid_r <= svalid_nxt;
      outv_r   <= outv_nxt;
      k_r      <= k_nxt;
      sidx_r   <= sidx_nxt;
      if (cfg_we) max_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    base_r   <= base_nxt;
    tot_r    <= tot_nxt;
    acc_r    <= acc_nxt;
    rowd_r   <= rowd_nxt;
    first_r  <= first_nxt;
    blk_r    <= blk_nxt;
    status_r <= status_nxt;
    rslot_r  <= rslot_nxt;
    rblk_r   <= rblk_nxt;
    rcnt_r   <= rcnt_nxt;
    out_r    <= out_nxt;
    fb_r     <= FBW'(free_r) * FBW'(BLOCK_BYTES);
  end

  assign in_stall  = (state_r != FSM_IDLE);
  assign out_valid = outv_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// ===== sim/tb_file_block_allocator_core.sv =====
// Self-checking testbench for file_block_allocator_core: directed table, then
// random command items, checked against an in-bench allocator predictor.
// Depends on fba_pkg and the file_block_allocator_core RTL.
`timescale 1ns / 1ps

module tb_file_block_allocator_core;
  import fba_pkg::*;

  localparam int NBLK  = NUM_BLOCKS_DEF;
  localparam int NSLOT = FILE_SLOTS_DEF;
  localparam int BPF   = BLOCKS_PER_FILE_DEF;
  localparam int BSIZE = BLOCK_BYTES_DEF;
  localparam int BASE  = DATA_BASE_DEF;
  localparam logic [25:0] FULL_FREE = 26'(NBLK * BSIZE);
  localparam logic [23:0] LIMIT_MAX = 24'hFFFFFF;
  localparam logic [23:0] LIMIT_MIN = 24'd0;
  // undefined action codes; the block treats them as a free-space query
  localparam logic [2:0] ACT_SPARE5 = 3'd5;
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam int DIR_ROWS = 24;

  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  file_block_allocator_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Allocator shadow: bitmap, slot table, per-slot block lists, free count.
  // ---------------------------------------------------------------------------
  bit          blk_used  [NBLK];
  bit          slot_live [NSLOT];
  int          slot_blocks[NSLOT];
  logic [11:0] blk_list  [NSLOT*BPF];
  int          free_blocks = NBLK;
  logic [23:0] size_limit = MAX_FILE_BYTES_RST;

  out_item_t   pending_results[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          fill_burst = 0;

  task automatic apply_command(input in_item_t it, output out_item_t r);
    longint unsigned nbytes, need;
    int s, k, cur, slot_sel;
    r = '0;
    r.status = STAT_OK;
    case (it.action)
      ACT_ALLOC: begin
        nbytes = it.file_bytes;
        need = (nbytes + BSIZE - 1) / BSIZE;
        slot_sel = -1;
        for (s = 0; s < NSLOT; s++)
          if (!slot_live[s] && slot_sel < 0) slot_sel = s;
        if (nbytes > longint'(free_blocks) * BSIZE) begin
          r.status = STAT_NO_SPACE;
        end else if (nbytes > size_limit || need > BPF) begin
          r.status = STAT_TOO_BIG;   // includes the too-many-blocks case
        end else if (slot_sel < 0) begin
          r.status = STAT_NO_SLOT;
        end else begin
          // first fit: the lowest free block only moves up within one request
          cur = 0;
          for (k = 0; k < int'(need); k++) begin
            while (blk_used[cur]) cur++;
            blk_used[cur] = 1'b1;
            free_blocks--;
            blk_list[slot_sel*BPF + k] = 12'(cur);
          end
          slot_live[slot_sel]   = 1'b1;
          slot_blocks[slot_sel] = int'(need);
          r.slot_out    = 7'(slot_sel);
          r.block_count = 11'(need);
          if (need > 0) r.block_number = 13'(blk_list[slot_sel*BPF] + BASE);
        end
      end
      ACT_DELETE: begin
        r.slot_out = it.file_index;
        if (!slot_live[it.file_index]) begin
          r.status = STAT_BAD_SLOT;
        end else begin
          for (k = 0; k < slot_blocks[it.file_index]; k++) begin
            cur = blk_list[it.file_index*BPF + k];
            if (blk_used[cur]) begin
              blk_used[cur] = 1'b0;
              free_blocks++;
            end
          end
          slot_live[it.file_index]   = 1'b0;
          slot_blocks[it.file_index] = 0;
        end
      end
      ACT_READ: begin
        r.slot_out = it.file_index;
        if (!slot_live[it.file_index]) begin
          r.status = STAT_BAD_SLOT;
        end else begin
          r.block_count = 11'(slot_blocks[it.file_index]);
          if (it.block_position >= slot_blocks[it.file_index])
            r.status = STAT_PAST_END;
          else
            r.block_number = 13'(blk_list[it.file_index*BPF + it.block_position] + BASE);
        end
      end
      ACT_FORMAT: begin
        for (k = 0; k < NBLK; k++) blk_used[k] = 1'b0;
        for (k = 0; k < NSLOT; k++) begin
          slot_live[k]   = 1'b0;
          slot_blocks[k] = 0;
        end
        free_blocks = NBLK;
      end
      default: ;  // query and spare codes only report free space
    endcase
    r.free_bytes = 26'(longint'(free_blocks) * BSIZE);
  endtask

  // random valid slot, or -1 when the table is empty
  function automatic int pick_live();
    int start, k;
    start = $urandom_range(NSLOT - 1);
    for (k = 0; k < NSLOT; k++)
      if (slot_live[(start + k) % NSLOT]) return (start + k) % NSLOT;
    return -1;
  endfunction

  // Mostly well-formed traffic: allocs of modest size, reads and deletes
  // of live slots, with some noise, spare codes and the odd format.
  task automatic make_command(output in_item_t it);
    int sel, sz, live;
    it.action         = ACT_QUERY;
    it.file_bytes     = $urandom();
    it.file_index     = 7'($urandom());
    it.block_position = 11'($urandom());
    if (fill_burst > 0) begin
      // fill the slot table to reach the no-free-slot case
      fill_burst--;
      it.action     = ACT_ALLOC;
      it.file_bytes = $urandom_range(BSIZE);
      return;
    end
    sel = $urandom_range(99);
    if (sel < 42) begin
      it.action = ACT_ALLOC;
      sz = $urandom_range(99);
      if (sz < 70)      it.file_bytes = $urandom_range(24 * BSIZE);
      else if (sz < 80) it.file_bytes = $urandom_range(1, 40) * BSIZE + $urandom_range(2) - 1;
      else if (sz < 88) it.file_bytes = $urandom_range(int'(LIMIT_MAX));
      else if (sz < 95) it.file_bytes = $urandom();
      else              it.file_bytes = free_blocks * BSIZE + $urandom_range(1);
    end else if (sel < 62) begin
      it.action = ACT_READ;
      live = pick_live();
      if (live >= 0) begin
        it.file_index = 7'(live);
        if ($urandom_range(9) < 8 && slot_blocks[live] > 0)
          it.block_position = 11'($urandom_range(slot_blocks[live] - 1));
        else if ($urandom_range(1))
          it.block_position = 11'(slot_blocks[live]);
      end
    end else if (sel < 76) begin
      it.action = ACT_DELETE;
      live = pick_live();
      if (live >= 0) it.file_index = 7'(live);
    end else if (sel < 86) begin
      it.action = $urandom_range(1) ? ACT_READ : ACT_DELETE;   // any index
    end else if (sel < 91) begin
      it.action = ACT_QUERY;
    end else if (sel < 97) begin
      case ($urandom_range(2))
        0:       it.action = ACT_SPARE5;
        1:       it.action = ACT_SPARE6;
        default: it.action = ACT_SPARE7;
      endcase
    end else if (sel < 98) begin
      it.action = ACT_FORMAT;
    end else begin
      fill_burst = 130;
    end
  endtask

  // Present one item from a falling edge; returns at the falling edge after
  // acceptance with in_valid still high.
  task automatic send_command(input in_item_t it, input bit typed, input out_item_t res);
    out_item_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_command(it, want);
    pending_results.push_back(typed ? res : want);
    @(negedge clk);
  endtask

  task automatic set_limit(input logic [23:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    size_limit = v;
  endtask

  // wait for every result, then for the block to settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_phase(input int count, input logic [23:0] lim,
                              input int s_pct, input int r_pct);
    in_item_t it;
    int n;
    set_limit(lim);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    n = 0;
    while (n < count) begin
      make_command(it);
      if (fill_burst == 130) continue;   // burst just armed, no item yet
      send_command(it, 1'b0, '0);
      n++;
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic cmp_field(input string nm, input longint e, input longint g);
    if (e != g) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, e, g);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
        errors++;
      end else begin
        e = pending_results.pop_front();
        cmp_field("status",       e.status,       out_item.status);
        cmp_field("slot_out",     e.slot_out,     out_item.slot_out);
        cmp_field("block_number", e.block_number, out_item.block_number);
        cmp_field("block_count",  e.block_count,  out_item.block_count);
        cmp_field("free_bytes",   e.free_bytes,   out_item.free_bytes);
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // ---------------------------------------------------------------------------
  // Directed table; typed results only where obvious.
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab[DIR_ROWS];

  function automatic dir_row_t row(input logic [2:0] a, input logic [31:0] b,
                                   input logic [6:0] i, input logic [10:0] p,
                                   input bit typed = 1'b0,
                                   input out_item_t r = '0);
    dir_row_t d;
    d.cmd.action = a;
    d.cmd.file_bytes = b;
    d.cmd.file_index = i;
    d.cmd.block_position = p;
    d.typed = typed;
    d.res = r;
    return d;
  endfunction

  initial begin
    dir_tab[0]  = row(ACT_QUERY, 0, 0, 0, 1, '{STAT_OK, 0, 0, 0, FULL_FREE});
    dir_tab[1]  = row(ACT_ALLOC, 0, 0, 0, 1, '{STAT_OK, 0, 0, 0, FULL_FREE});  // empty file
    dir_tab[2]  = row(ACT_ALLOC, 1, 0, 0, 1, '{STAT_OK, 1, BASE, 1, FULL_FREE - BSIZE});
    dir_tab[3]  = row(ACT_ALLOC, 32'hFFFF_FFFF, 0, 0, 1,
                      '{STAT_NO_SPACE, 0, 0, 0, FULL_FREE - BSIZE});
    dir_tab[4]  = row(ACT_ALLOC, MAX_FILE_BYTES_RST + 1, 0, 0, 1,
                      '{STAT_TOO_BIG, 0, 0, 0, FULL_FREE - BSIZE});
    dir_tab[5]  = row(ACT_ALLOC, MAX_FILE_BYTES_RST, 0, 0);      // largest file
    dir_tab[6]  = row(ACT_READ, 0, 2, BPF - 1);
    dir_tab[7]  = row(ACT_READ, 0, 2, 11'h7FF);                 // past end
    dir_tab[8]  = row(ACT_READ, 0, 1, 0);
    dir_tab[9]  = row(ACT_READ, 0, 7'h7F, 0);                   // slot not valid
    dir_tab[10] = row(ACT_DELETE, 0, 7'h7F, 0);
    dir_tab[11] = row(ACT_DELETE, 0, 0, 0);                     // delete empty file
    dir_tab[12] = row(ACT_READ, 0, 0, 0);
    dir_tab[13] = row(ACT_SPARE5, 0, 0, 0);
    dir_tab[14] = row(ACT_SPARE6, 32'hFFFF_FFFF, 7'h7F, 11'h7FF);
    dir_tab[15] = row(ACT_SPARE7, 0, 0, 0);
    dir_tab[16] = row(ACT_ALLOC, 2 * BSIZE + 1, 0, 0);
    dir_tab[17] = row(ACT_DELETE, 0, 2, 0);
    dir_tab[18] = row(ACT_ALLOC, BSIZE + 1, 0, 0);              // reuses freed blocks
    dir_tab[19] = row(ACT_READ, 0, 0, 1);
    dir_tab[20] = row(ACT_FORMAT, 0, 0, 0);
    dir_tab[21] = row(ACT_QUERY, 0, 0, 0, 1, '{STAT_OK, 0, 0, 0, FULL_FREE});
    dir_tab[22] = row(ACT_READ, 0, 1, 0, 1, '{STAT_BAD_SLOT, 1, 0, 0, FULL_FREE});
    dir_tab[23] = row(ACT_ALLOC, 32'(FULL_FREE), 0, 0);         // equals free space
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset limit, no idling
    foreach (dir_tab[i]) send_command(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);
    drain();

    // largest limit: allocations above the per-file block cap show up
    fill_burst = 0;
    random_phase(90, LIMIT_MAX, 17, 65);
    // zero limit: only empty files fit
    random_phase(25, LIMIT_MIN, 65, 17);
    random_phase(70, 24'($urandom_range(BSIZE, int'(MAX_FILE_BYTES_RST))), 65, 17);
    // back at the reset limit, no idling on either side
    random_phase(80, MAX_FILE_BYTES_RST, 0, 0);

    if (errors == 0)
      $display("file_block_allocator_core test passed");
    else
      $display("file_block_allocator_core test failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("file_block_allocator_core test failed");
    $finish;
  end

endmodule
